// File: hw/rtl/pti_pkg.sv
// pti_pkg: shared widths and controller/datapath handshake structs
// for the palindromic tree insert core; no dependencies
package pti_pkg;

    localparam int SYM_W = 5;   // letter code width
    localparam int OUT_W = 13;  // width of every numeric result field

    // commands from the controller to the datapath, at most one per cycle
    typedef struct packed {
        logic load;       // take an item, apply restart, append the letter
        logic advance;    // follow the suffix link of the current node
        logic mark_now;   // first walk ended, remember the extended node
        logic take_edge;  // edge exists, it becomes the longest suffix
        logic create;     // second walk ended, make the new node
        logic out_load;   // copy the result into the output register
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic reject;      // letter out of range or text full
        logic idx_ok;      // mirror position lies inside the text
        logic text_match;  // letter at the mirror position matches
        logic edge_valid;  // edge lookup hit a node of the current tree
    } dp_status_t;

endpackage

// File: hw/rtl/pti_in_if.sv
// pti_in_if: valid/ready channel that carries one letter item
// depends on pti_pkg
interface pti_in_if;
    import pti_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             restart;

    modport source (output valid, output symbol, output restart, input ready);
    modport sink   (input valid, input symbol, input restart, output ready);
endinterface

// File: hw/rtl/pti_out_if.sv
// pti_out_if: valid/ready channel that carries one insertion result item
// depends on pti_pkg
interface pti_out_if;
    import pti_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] suffix_node;
    logic [OUT_W-1:0] suffix_length;
    logic             created;
    logic [OUT_W-1:0] distinct_count;
    logic             overflow;

    modport source (output valid, output suffix_node, output suffix_length,
                    output created, output distinct_count, output overflow,
                    input ready);
    modport sink   (input valid, input suffix_node, input suffix_length,
                    input created, input distinct_count, input overflow,
                    output ready);
endinterface

// File: hw/rtl/pti_dpath.sv
// pti_dpath: text, node and edge memories, walk registers and result register
// depends on pti_pkg; driven by pti_ctrl through dp_cmd_t / dp_status_t
module pti_dpath #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pti_pkg::SYM_W-1:0] symbol,
    input  logic                      restart,
    input  pti_pkg::dp_cmd_t          cmd,
    output pti_pkg::dp_status_t       status,
    output logic [pti_pkg::OUT_W-1:0] suffix_node,
    output logic [pti_pkg::OUT_W-1:0] suffix_length,
    output logic                      created,
    output logic [pti_pkg::OUT_W-1:0] distinct_count,
    output logic                      overflow
);
    import pti_pkg::*;

    localparam int NODE_CAP   = MAX_LEN + 2;
    localparam int NW         = $clog2(NODE_CAP);
    localparam int PW         = $clog2(MAX_LEN + 1);
    localparam int EDGE_DEPTH = NODE_CAP * ALPHABET;
    localparam int EW         = $clog2(EDGE_DEPTH);

    // memories; none is cleared, an edge counts only if its child node
    // belongs to the current tree and records this parent and letter
    logic [SYM_W-1:0] text_mem [MAX_LEN + 1];
    logic [PW-1:0]    len_mem  [NODE_CAP];
    logic [NW-1:0]    link_mem [NODE_CAP];
    logic [NW-1:0]    par_mem  [NODE_CAP];
    logic [SYM_W-1:0] esym_mem [NODE_CAP];
    logic [NW-1:0]    edge_mem [EDGE_DEPTH];

    // tree state
    logic [PW-1:0] pos_reg;
    logic [NW-1:0] longest_reg;
    logic [PW-1:0] longest_len_reg;
    logic [NW-1:0] total_reg;

    // walk registers
    logic [SYM_W-1:0] sym_reg;
    logic [NW-1:0]    node_reg;
    logic [NW-1:0]    now_reg;
    logic [PW:0]      len_now_reg;
    logic [EW-1:0]    edge_wr_addr_reg;
    logic             created_reg;
    logic             ovf_reg;

    // registered read data
    logic [PW-1:0]    len_rd_reg;
    logic [NW-1:0]    link_rd_reg;
    logic [SYM_W-1:0] text_rd_reg;
    logic [NW-1:0]    edge_rd_reg;
    logic [NW-1:0]    par_rd_reg;
    logic [SYM_W-1:0] esym_rd_reg;

    // result register
    logic [OUT_W-1:0] suffix_node_reg;
    logic [OUT_W-1:0] suffix_length_reg;
    logic             created_out_reg;
    logic [OUT_W-1:0] distinct_count_reg;
    logic             overflow_reg;

    logic [PW-1:0] pos_base;
    logic [PW-1:0] pos_inc;
    logic [NW-1:0] longest_base;
    logic          reject;
    logic [PW:0]   len_of;     // two's complement, odd root is -1
    logic [NW-1:0] link_of;
    logic [PW+1:0] idx;        // two's complement mirror position
    logic [EW-1:0] edge_addr;
    logic          edge_valid;
    logic [NW-1:0] fresh;
    logic [PW-1:0] len_new;

    assign pos_base     = restart ? '0 : pos_reg;
    assign pos_inc      = pos_base + 1'b1;
    assign longest_base = restart ? '0 : longest_reg;
    assign reject       = (32'(symbol) >= 32'(ALPHABET)) || (32'(pos_base) >= 32'(MAX_LEN));

    // roots are fixed: even root length 0, odd root length -1, both link to the odd root
    always_comb
    begin
        priority if (node_reg == NW'(0))
        begin
            len_of = '0;
        end
        else if (node_reg == NW'(1))
        begin
            len_of = '1;
        end
        else
        begin
            len_of = {1'b0, len_rd_reg};
        end
    end

    assign link_of = (node_reg < NW'(2)) ? NW'(1) : link_rd_reg;

    assign idx        = {2'b00, pos_reg} - (PW + 2)'(1) - {len_of[PW], len_of};
    assign edge_addr  = EW'(node_reg) * EW'(ALPHABET) + EW'(sym_reg);
    assign edge_valid = (edge_rd_reg >= NW'(2)) && (edge_rd_reg <= total_reg) &&
                        (par_rd_reg == node_reg) && (esym_rd_reg == sym_reg);
    assign fresh      = total_reg + 1'b1;
    assign len_new    = PW'(len_now_reg + (PW + 1)'(2));

    assign status.reject     = reject;
    assign status.idx_ok     = !idx[PW+1] && (idx != '0);
    assign status.text_match = (text_rd_reg == sym_reg);
    assign status.edge_valid = edge_valid;

    // memory reads, always running at the addresses the walk holds steady
    always_ff @(posedge clk)
    begin
        len_rd_reg  <= len_mem[node_reg];
        link_rd_reg <= link_mem[node_reg];
        text_rd_reg <= text_mem[idx[PW-1:0]];
        edge_rd_reg <= edge_mem[edge_addr];
        par_rd_reg  <= par_mem[edge_rd_reg];
        esym_rd_reg <= esym_mem[edge_rd_reg];
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.load && !reject)
        begin
            text_mem[pos_inc] <= symbol;
        end
        if (cmd.create)
        begin
            len_mem[fresh]             <= len_new;
            par_mem[fresh]             <= now_reg;
            esym_mem[fresh]            <= sym_reg;
            edge_mem[edge_wr_addr_reg] <= fresh;
            if (edge_valid)
            begin
                link_mem[fresh] <= edge_rd_reg;
            end
            else
            begin
                link_mem[fresh] <= '0;
            end
        end
    end

    // tree state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            longest_reg     <= '0;
            longest_len_reg <= '0;
            total_reg       <= NW'(1);
        end
        else if (cmd.load)
        begin
            pos_reg         <= reject ? pos_base : pos_inc;
            longest_reg     <= longest_base;
            longest_len_reg <= restart ? '0 : longest_len_reg;
            total_reg       <= restart ? NW'(1) : total_reg;
        end
        else if (cmd.take_edge)
        begin
            longest_reg     <= edge_rd_reg;
            longest_len_reg <= len_new;
        end
        else if (cmd.create)
        begin
            total_reg       <= fresh;
            longest_reg     <= fresh;
            longest_len_reg <= len_new;
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_reg     <= symbol;
            node_reg    <= longest_base;
            created_reg <= 1'b0;
            ovf_reg     <= reject;
        end
        if (cmd.advance)
        begin
            node_reg <= link_of;
        end
        if (cmd.mark_now)
        begin
            now_reg          <= node_reg;
            len_now_reg      <= len_of;
            edge_wr_addr_reg <= edge_addr;
        end
        if (cmd.create)
        begin
            created_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            suffix_node_reg    <= OUT_W'(longest_reg);
            suffix_length_reg  <= OUT_W'(longest_len_reg);
            created_out_reg    <= created_reg;
            distinct_count_reg <= OUT_W'(total_reg - 1'b1);
            overflow_reg       <= ovf_reg;
        end
    end

    assign suffix_node    = suffix_node_reg;
    assign suffix_length  = suffix_length_reg;
    assign created        = created_out_reg;
    assign distinct_count = distinct_count_reg;
    assign overflow       = overflow_reg;

endmodule

// File: hw/rtl/pti_ctrl.sv
// pti_ctrl: sequencer for suffix link walks, edge lookup and node creation
// depends on pti_pkg; commands pti_dpath
module pti_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pti_pkg::dp_status_t status,
    output pti_pkg::dp_cmd_t    cmd
);
    import pti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_IDX,
        S_WALK_CMP,
        S_EDGE_DEC,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   back_reg, back_next;        // second walk, for the new node's link
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        back_next      = back_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    back_next  = 1'b0;
                    state_next = status.reject ? S_RESULT : S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_IDX;
            end
            S_WALK_IDX:
            begin
                if (status.idx_ok)
                begin
                    state_next = S_WALK_CMP;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_WALK_RD;
                end
            end
            S_WALK_CMP:
            begin
                if (status.text_match)
                begin
                    cmd.mark_now = !back_reg;
                    state_next   = S_EDGE_DEC;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_WALK_RD;
                end
            end
            S_EDGE_DEC:
            begin
                if (back_reg)
                begin
                    cmd.create = 1'b1;
                    state_next = S_RESULT;
                end
                else if (status.edge_valid)
                begin
                    cmd.take_edge = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    // start the second walk from the link of the extended node
                    cmd.advance = 1'b1;
                    back_next   = 1'b1;
                    state_next  = S_WALK_RD;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/palindromic_tree_insert_core.sv
// palindromic_tree_insert_core: top level of the eertree insertion block
// depends on pti_pkg, pti_in_if, pti_out_if, pti_ctrl, pti_dpath
//
//  channel   dir   payload                                          handshake
//  letters   in    symbol[4:0], restart                             valid/ready
//  results   out   suffix_node, suffix_length, created,             valid/ready
//                  distinct_count, overflow (numeric fields 13 bit)
//
// per item: a rejected letter goes straight to the result; else the suffix link
// walk reads each node, checks its mirror position and compares the letter (no
// compare if the mirror is outside the text); a new node adds a suffix link walk
// reset: asynchronous, leaves the two roots; node and edge memories are never swept
// a finished result waits in the output register while the next item is taken,
// and a later result waits in the core until that register is free
module palindromic_tree_insert_core #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input logic       clk,
    input logic       rst_n,
    pti_in_if.sink    letters,
    pti_out_if.source results
);
    import pti_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: walk, edge check, node creation, result handoff
    pti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (letters.valid),
        .in_ready  (letters.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // memories, tree registers and result register
    pti_dpath #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .symbol         (letters.symbol),
        .restart        (letters.restart),
        .cmd            (cmd),
        .status         (status),
        .suffix_node    (results.suffix_node),
        .suffix_length  (results.suffix_length),
        .created        (results.created),
        .distinct_count (results.distinct_count),
        .overflow       (results.overflow)
    );

`ifndef ASSERT_OFF
    // an accepted item keeps the core busy, so ready drops once the item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        letters.valid && letters.ready |=> !letters.ready)
        else $error("item taken while previous item still in work");

    // the controller never issues two datapath commands in one cycle
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // a loaded result is shown on the next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> results.valid)
        else $error("result register loaded but not valid");

    // a new node is never reported with a rejected letter, and is counted
    a_created_counted: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.created |-> !results.overflow && results.distinct_count != '0)
        else $error("created node inconsistent with overflow or count");
`endif

endmodule
